[hw/rtl/key_value_table_top_assert.svh]
// Assertion macros shared by the key-value table RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define KEY_VALUE_TABLE_TOP_ASSERT_SVH

// Property holds at every clock edge.
`define KVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("key_value_table assertion failed");

// Antecedent implies consequent in the same cycle.
`define KVT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key_value_table implication failed");

// Antecedent implies consequent in the next cycle.
`define KVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key_value_table next-cycle check failed");

`endif

[hw/rtl/kvt_pkg.sv]
// Package for the key-value table: command codes, register index, request,
// token and result types. No dependencies.
`default_nettype none

package kvt_pkg;

  localparam int unsigned KVT_CAPACITY = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned COUNT_W      = 6;
  localparam int unsigned PADDR_W      = 3;

  localparam logic [DATA_W-1:0] NULL_RESET = 32'hFFFF_FFFF;

  // Register word index (paddr[2]).
  localparam logic REG_NULL_VALUE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2
  } kvt_cmd_e;

  // Request held steady while its token walks the cell row.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } kvt_req_t;

  // Token handed from cell to cell.
  typedef struct packed {
    logic              active;
    logic              found;
    logic [DATA_W-1:0] result;
    logic              free_seen;
  } kvt_tok_t;

  // Finished result of one request.
  typedef struct packed {
    logic               found;
    logic [DATA_W-1:0]  result_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic               table_full;
  } kvt_res_t;

endpackage

`default_nettype wire

[hw/rtl/key_value_table_top.sv]
// Key-value table: CAPACITY cells in a row; a token walks one cell per cycle.
// A request passes the launch register, the token register of each cell, the
// hold register and the output register. A new request is accepted only once
// the last token has left the cell row and its held result has moved on.
// Reset clears all valid bits, the entry count and sets null_value to -1.
// Depends on kvt_pkg, kvt_ctrl and kvt_cell.
`default_nettype none

module key_value_table_top #(
  parameter int unsigned CAPACITY = kvt_pkg::KVT_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kvt_pkg::PADDR_W-1:0]  paddr,
  input  logic [kvt_pkg::DATA_W-1:0]   pwdata,
  output logic [kvt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [kvt_pkg::CMD_W-1:0]    cmd_i,
  input  logic [kvt_pkg::DATA_W-1:0]   key_i,
  input  logic [kvt_pkg::DATA_W-1:0]   value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [kvt_pkg::DATA_W-1:0]   result_value_o,
  output logic [kvt_pkg::COUNT_W-1:0]  entry_count_o,
  output logic                         is_empty_o,
  output logic                         table_full_o
);
  import kvt_pkg::*;

  logic [DATA_W-1:0] null_q;
  logic              cfg_wr;
  kvt_req_t          req;
  kvt_tok_t          tok [CAPACITY+1];
  logic              commit;
  kvt_res_t          res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NULL_VALUE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      null_q <= NULL_RESET;
    end else if (cfg_wr) begin
      null_q <= pwdata;
    end
  end

  assign prdata = (paddr[2] == REG_NULL_VALUE) ? null_q : '0;

  kvt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_i        (key_i),
    .value_i      (value_i),
    .null_value_i (null_q),
    .req_o        (req),
    .head_o       (tok[0]),
    .tail_i       (tok[CAPACITY]),
    .commit_o     (commit),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .req_i    (req),
      .tok_i    (tok[i]),
      .commit_i (commit),
      .tok_o    (tok[i+1])
    );
  end

  assign found_o        = res.found;
  assign result_value_o = res.result_value;
  assign entry_count_o  = res.entry_count;
  assign is_empty_o     = res.is_empty;
  assign table_full_o   = res.table_full;

endmodule

`default_nettype wire

[hw/rtl/kvt_cell.sv]
// One table cell: key, value and valid bit, compared against the broadcast
// request as the token passes. Depends on kvt_pkg.
`default_nettype none

module kvt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kvt_pkg::kvt_req_t req_i,
  input  kvt_pkg::kvt_tok_t tok_i,
  input  logic             commit_i,
  output kvt_pkg::kvt_tok_t tok_o
);
  import kvt_pkg::*;

  logic              valid_q;
  logic              claim_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] value_q;
  kvt_tok_t          tok_q;
  kvt_tok_t          tok_d;
  logic              hit;
  logic              claim;
  logic              is_ins;
  logic              is_rem;

  assign is_ins = (req_i.cmd == CMD_INSERT);
  assign is_rem = (req_i.cmd == CMD_REMOVE);
  assign hit    = tok_i.active & valid_q & (key_q == req_i.key);
  // First free cell along the row claims a new key, pending commit.
  assign claim  = tok_i.active & ~valid_q & ~tok_i.free_seen & is_ins;

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.found  = 1'b1;
      tok_d.result = value_q;
    end
    if (tok_i.active && !valid_q) begin
      tok_d.free_seen = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      claim_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (tok_i.active) begin
        claim_q <= claim;
      end
      if (commit_i && claim_q) begin
        valid_q <= 1'b1;
      end else if (hit && is_rem) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_i && claim_q) begin
      key_q   <= req_i.key;
      value_q <= req_i.value;
    end else if (hit && is_ins) begin
      value_q <= req_i.value;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

[hw/rtl/kvt_ctrl.sv]
// Request control: launches tokens into the cell row, resolves the tail token,
// keeps the entry count and drives the result channel. Depends on kvt_pkg.
`default_nettype none

`include "key_value_table_top_assert.svh"

module kvt_ctrl #(
  parameter int unsigned CAPACITY = kvt_pkg::KVT_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kvt_pkg::CMD_W-1:0]   cmd_i,
  input  logic [kvt_pkg::DATA_W-1:0]  key_i,
  input  logic [kvt_pkg::DATA_W-1:0]  value_i,
  input  logic [kvt_pkg::DATA_W-1:0]  null_value_i,
  output kvt_pkg::kvt_req_t           req_o,
  output kvt_pkg::kvt_tok_t           head_o,
  input  kvt_pkg::kvt_tok_t           tail_i,
  output logic                        commit_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output kvt_pkg::kvt_res_t           res_o
);
  import kvt_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e          state_q;
  logic            launch_q;
  logic            hold_vld_q;
  logic            out_valid_q;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  kvt_req_t        req_q;
  kvt_res_t        hold_q;
  kvt_res_t        out_q;
  kvt_res_t        res_d;
  logic            accept;
  logic            known;
  logic            is_ins;
  logic            add;
  logic            dec;
  logic            move;

  assign in_ready_o = (state_q == S_IDLE) && !hold_vld_q;
  assign accept     = in_valid_i && in_ready_o;

  assign is_ins = (req_q.cmd == CMD_INSERT);
  assign known  = (req_q.cmd == CMD_INSERT) || (req_q.cmd == CMD_LOOKUP) ||
                  (req_q.cmd == CMD_REMOVE);
  assign add    = is_ins && !tail_i.found && tail_i.free_seen;
  assign dec    = (req_q.cmd == CMD_REMOVE) && tail_i.found;
  assign commit_o = tail_i.active && add;

  always_comb begin
    count_d = count_q;
    if (tail_i.active) begin
      if (add) begin
        count_d = count_q + CntW'(1);
      end else if (dec) begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_comb begin
    res_d.found        = tail_i.found && known;
    res_d.result_value = res_d.found ? tail_i.result : null_value_i;
    res_d.entry_count  = COUNT_W'(count_d);
    res_d.is_empty     = (count_d == '0);
    res_d.table_full   = is_ins && !tail_i.found && !tail_i.free_seen;
  end

  always_comb begin
    head_o           = '0;
    head_o.active    = launch_q;
  end

  // Advance the held result into the output register once it frees up.
  assign move = hold_vld_q && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launch_q    <= 1'b0;
      hold_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      launch_q <= accept;
      count_q  <= count_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (tail_i.active) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (tail_i.active) begin
        hold_vld_q <= 1'b1;
      end else if (move) begin
        hold_vld_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cmd   <= cmd_i;
      req_q.key   <= key_i;
      req_q.value <= value_i;
    end
    if (tail_i.active) begin
      hold_q <= res_d;
    end
    if (move) begin
      out_q <= hold_q;
    end
  end

  assign req_o       = req_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  `KVT_ASSERT(a_count_range, count_q <= CntW'(CAPACITY))
  `KVT_ASSERT_IMP(a_tail_busy, tail_i.active, state_q == S_BUSY)
  `KVT_ASSERT_NEXT(a_accept_busy, accept, state_q == S_BUSY)
  `KVT_ASSERT_NEXT(a_hold_drain, hold_vld_q && !out_valid_q, out_valid_q && !hold_vld_q)

endmodule

`default_nettype wire
